FILE: sv/brac_pkg.sv
// Package for the bilinear resize block: sizes, register indexes, types.
// No dependencies; used by every module of the block but brac_ram.
package brac_pkg;
    localparam int MaxPlanes    = 4;
    localparam int MaxInHeight  = 64;
    localparam int MaxInWidth   = 64;
    localparam int SampleBits   = 16;
    localparam int FractionBits = 16;
    localparam int GuardBits    = 6;
    localparam int PlaneBits    = $clog2(MaxPlanes);
    localparam int RowBits      = $clog2(MaxInHeight);
    localparam int ColBits      = $clog2(MaxInWidth);
    localparam int AddrBits     = PlaneBits + RowBits + ColBits;
    localparam int StoreDepth   = MaxPlanes * MaxInHeight * MaxInWidth;
    localparam int CoordBits    = 10;
    localparam int InDimBits    = 7;
    localparam int OutDimBits   = 11;
    // position numerator: coord*(in-1) << F
    localparam int NumBits      = CoordBits + InDimBits + FractionBits;
    localparam int QuotBits     = NumBits;

    localparam logic [1:0] RegInHeight  = 2'd0;
    localparam logic [1:0] RegInWidth   = 2'd1;
    localparam logic [1:0] RegOutHeight = 2'd2;
    localparam logic [1:0] RegOutWidth  = 2'd3;

    localparam logic OpLoad   = 1'b0;
    localparam logic OpInterp = 1'b1;

    typedef enum logic [3:0] {
        t_IDLE, t_DIV, t_RD0, t_RD1, t_RD2, t_RD3, t_BLEND, t_VERT, t_OUT
    } t_state;

    // divider control
    typedef struct packed {
        logic start;
        logic busy;
    } t_div_ctl;
endpackage

FILE: sv/bilinear_resize_align_corners.sv
// Bilinear resize with aligned corners: top level, sequencer and store.
// Depends on brac_pkg, brac_ram, brac_div and brac_blend.
//
// A load word writes one signed Q8.8 sample into a 16384-entry single-port
// sample memory (4 planes x 64 rows x 64 columns) and gives no result. An
// interpolate word maps its output row and column to source positions with a
// bit-serial divider (each a start, 33 quotient bits and a capture; rows then
// columns), then reads the four neighbors from the one memory port while the
// blend unit multiplies each as it arrives, and finishes with the vertical
// blend, rounding and saturation. A rejected query presents its error word in
// the cycle after it is accepted. Items are handled one at a time; the result
// waits in an output register, and the next word is accepted as soon as it
// goes, in the same cycle.
// Memory entries never loaded read as anything.
module bilinear_resize_align_corners (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [1:0]  i_plane,
    input  logic [9:0]  i_row,
    input  logic [9:0]  i_col,
    input  logic signed [15:0] i_sample,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [15:0] o_result_sample,
    output logic        o_coordinate_error,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);
    localparam int F = brac_pkg::FractionBits;

    brac_pkg::t_state r_state, n_state;
    logic [6:0]  r_in_h, r_in_w;
    logic [10:0] r_out_h, r_out_w;
    logic [1:0]  r_plane;
    logic [9:0]  r_row, r_col;
    logic        r_axis;               // 0 rows, 1 columns
    logic        r_div_run;
    logic [5:0]  r_y0, r_x0, r_y1, r_x1;
    logic [F-1:0] r_fy, r_fx;
    logic        r_ovalid;
    logic signed [15:0] r_res;
    logic        r_err;
    logic [2:0]  r_step;

    logic        w_accept, w_take, w_ovalid_set;
    logic [6:0]  w_ih, w_iw, w_idim;
    logic [10:0] w_odim;
    logic [9:0]  w_coord;
    logic [brac_pkg::NumBits-1:0] w_num;
    brac_pkg::t_div_ctl w_div;
    logic [brac_pkg::QuotBits-1:0] w_quot;
    logic        w_div_start;
    logic [brac_pkg::QuotBits-1:0] w_pos;
    logic [5:0]  w_ip, w_last;
    logic        w_we;
    logic [brac_pkg::AddrBits-1:0] w_addr;
    logic signed [15:0] w_rdata, w_blend;
    logic [2:0]  n_step;
    logic        w_bad;

    assign o_cfg_ready = (r_state == brac_pkg::t_IDLE);
    assign w_take   = r_ovalid && !i_stall;
    assign o_stall  = (r_state != brac_pkg::t_IDLE) || (r_ovalid && !w_take);
    assign w_accept = i_valid && !o_stall;

    // clamp input sizes to 1..max
    assign w_ih = (r_in_h == 7'd0) ? 7'd1 : ((r_in_h > 7'd64) ? 7'd64 : r_in_h);
    assign w_iw = (r_in_w == 7'd0) ? 7'd1 : ((r_in_w > 7'd64) ? 7'd64 : r_in_w);

    assign w_bad = ({1'b0, i_row} >= r_out_h) | ({1'b0, i_col} >= r_out_w);

    // divider operands for the current axis
    assign w_idim  = r_axis ? w_iw : w_ih;
    assign w_odim  = r_axis ? r_out_w : r_out_h;
    assign w_coord = r_axis ? r_col : r_row;
    assign w_num   = {17'(w_coord) * 17'(w_idim - 7'd1), 16'd0};
    assign w_pos   = (w_odim <= 11'd1) ? '0 : w_quot;
    assign w_last  = 6'(w_idim - 7'd1);
    assign w_ip    = (w_pos[brac_pkg::QuotBits-1:F] > 17'(w_last))
                   ? w_last : w_pos[F+5:F];

    // next state; r_step is registered alongside the memory read, so it arrives with the data it names
    always_comb begin
        n_state = r_state;
        n_step  = 3'd7;
        case (r_state)
            brac_pkg::t_IDLE: begin
                if (w_accept && i_operation == brac_pkg::OpInterp && !w_bad) begin
                    n_state = brac_pkg::t_DIV;
                end
            end
            brac_pkg::t_DIV: begin
                // leave once the column division is captured
                if (r_div_run && !w_div.busy && r_axis) begin
                    n_state = brac_pkg::t_RD0;
                end
            end
            brac_pkg::t_RD0: begin n_state = brac_pkg::t_RD1; n_step = 3'd0; end
            brac_pkg::t_RD1: begin n_state = brac_pkg::t_RD2; n_step = 3'd1; end
            brac_pkg::t_RD2: begin n_state = brac_pkg::t_RD3; n_step = 3'd2; end
            brac_pkg::t_RD3: begin n_state = brac_pkg::t_BLEND; n_step = 3'd3; end
            brac_pkg::t_BLEND: begin n_state = brac_pkg::t_VERT; n_step = 3'd4; end
            brac_pkg::t_VERT: n_state = brac_pkg::t_OUT;
            brac_pkg::t_OUT: n_state = brac_pkg::t_IDLE;
            default: n_state = brac_pkg::t_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= brac_pkg::t_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // result word appears after the blend or right after a rejected query
    assign w_ovalid_set = (r_state == brac_pkg::t_OUT)
                        || (w_accept && i_operation == brac_pkg::OpInterp && w_bad);

    // registers, output valid and divider sequencing: start, wait, capture; two axes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_h    <= 7'd1;
            r_in_w    <= 7'd1;
            r_out_h   <= 11'd1;
            r_out_w   <= 11'd1;
            r_ovalid  <= 1'b0;
            r_div_run <= 1'b0;
            r_axis    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    brac_pkg::RegInHeight:  r_in_h  <= i_cfg_data[6:0];
                    brac_pkg::RegInWidth:   r_in_w  <= i_cfg_data[6:0];
                    brac_pkg::RegOutHeight: r_out_h <= i_cfg_data;
                    brac_pkg::RegOutWidth:  r_out_w <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_ovalid_set) begin
                r_ovalid <= 1'b1;
            end else if (w_take) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                brac_pkg::t_IDLE: begin
                    if (w_accept && i_operation == brac_pkg::OpInterp && !w_bad) begin
                        r_axis    <= 1'b0;
                        r_div_run <= 1'b0;
                    end
                end
                brac_pkg::t_DIV: begin
                    if (!r_div_run) begin
                        r_div_run <= 1'b1;
                    end else if (!w_div.busy && !w_div.start) begin
                        r_div_run <= 1'b0;
                        if (!r_axis) begin
                            r_axis <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        if (w_accept) begin
            r_plane <= i_plane;
            r_row   <= i_row;
            r_col   <= i_col;
            if (i_operation == brac_pkg::OpInterp && w_bad) begin
                r_res <= '0;
                r_err <= 1'b1;
            end
        end
        if (r_state == brac_pkg::t_DIV && r_div_run && !w_div.busy && !w_div.start) begin
            if (!r_axis) begin
                r_y0 <= w_ip;
                r_y1 <= (w_ip < w_last) ? w_ip + 6'd1 : w_ip;
                r_fy <= w_pos[F-1:0];
            end else begin
                r_x0 <= w_ip;
                r_x1 <= (w_ip < w_last) ? w_ip + 6'd1 : w_ip;
                r_fx <= w_pos[F-1:0];
            end
        end
        if (r_state == brac_pkg::t_OUT) begin
            r_res <= w_blend;
            r_err <= 1'b0;
        end
    end

    assign w_div_start = (r_state == brac_pkg::t_DIV) && !r_div_run;

    brac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_odim - 11'd1),
        .o_ctl   (w_div),
        .o_quot  (w_quot)
    );

    // memory port: load writes, neighbor reads in order 00 01 10 11
    always_comb begin
        w_we   = w_accept && i_operation == brac_pkg::OpLoad
               && i_row < 10'd64 && i_col < 10'd64;
        w_addr = {i_plane, i_row[5:0], i_col[5:0]};
        case (r_state)
            brac_pkg::t_RD0: w_addr = {r_plane, r_y0, r_x0};
            brac_pkg::t_RD1: w_addr = {r_plane, r_y0, r_x1};
            brac_pkg::t_RD2: w_addr = {r_plane, r_y1, r_x0};
            brac_pkg::t_RD3: w_addr = {r_plane, r_y1, r_x1};
            default: ;
        endcase
    end

    brac_ram #(.Width(16), .Depth(brac_pkg::StoreDepth)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (i_sample),
        .o_rdata (w_rdata)
    );

    brac_blend u_blend (
        .i_clk    (i_clk),
        .i_step   (r_step),
        .i_sample (w_rdata),
        .i_fx     (r_fx),
        .i_fy     (r_fy),
        .o_result (w_blend)
    );

    assign o_valid            = r_ovalid;
    assign o_result_sample    = r_res;
    assign o_coordinate_error = r_err;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_coordinate_error |-> o_result_sample == 16'sd0)
        else $error("error word carries nonzero sample");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_sample))
        else $error("stalled result changed");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != brac_pkg::t_IDLE |-> o_stall)
        else $error("input taken while busy");
`endif
endmodule

FILE: sv/brac_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module brac_ram #(
    parameter int Width = 16,
    parameter int Depth = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/brac_div.sv
// Restoring divider, one quotient bit per cycle, for the coordinate map.
// Depends on brac_pkg.
module brac_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [brac_pkg::NumBits-1:0]         i_num,
    input  logic [brac_pkg::OutDimBits-1:0]      i_den,
    output brac_pkg::t_div_ctl                   o_ctl,
    output logic [brac_pkg::QuotBits-1:0]        o_quot
);
    localparam int CntBits = $clog2(brac_pkg::NumBits + 1);

    logic [brac_pkg::NumBits-1:0]    r_q, n_q;
    logic [brac_pkg::OutDimBits:0]   r_rem, n_rem;
    logic [brac_pkg::OutDimBits-1:0] r_den;
    logic [CntBits-1:0]              r_cnt, n_cnt;
    logic [brac_pkg::OutDimBits:0]   w_sh;

    always_comb begin
        w_sh  = {r_rem[brac_pkg::OutDimBits-1:0], r_q[brac_pkg::NumBits-1]};
        n_q   = {r_q[brac_pkg::NumBits-2:0], 1'b0};
        n_rem = w_sh;
        n_cnt = r_cnt;
        if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_sh - {1'b0, r_den};
                n_q[0] = 1'b1;
            end
        end else begin
            n_q   = r_q;
            n_rem = r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CntBits'(brac_pkg::NumBits);
        end else begin
            r_cnt <= n_cnt;
        end
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_ctl.start = i_start;
    assign o_ctl.busy  = (r_cnt != '0);
    assign o_quot      = r_q;
endmodule

FILE: sv/brac_blend.sv
// Bilinear blend datapath: one multiply-accumulate per step, rounding, saturation.
// Depends on brac_pkg.
module brac_blend (
    input  logic                                i_clk,
    input  logic [2:0]                          i_step,
    input  logic signed [brac_pkg::SampleBits-1:0] i_sample,
    input  logic [brac_pkg::FractionBits-1:0]   i_fx,
    input  logic [brac_pkg::FractionBits-1:0]   i_fy,
    output logic signed [brac_pkg::SampleBits-1:0] o_result
);
    localparam int F  = brac_pkg::FractionBits;
    localparam int SB = brac_pkg::SampleBits;
    localparam int G  = brac_pkg::GuardBits;
    localparam int AccBits = SB + F + 3;
    localparam int HBits   = SB + G + 2;
    localparam int VBits   = HBits + F + 2;

    logic signed [AccBits-1:0] r_acc;
    logic signed [HBits-1:0]   r_top, r_bot;
    logic signed [VBits-1:0]   r_v;
    logic signed [F+1:0]       w_wx, w_wy0, w_wy1;
    logic signed [AccBits-1:0] w_prod, w_sum, w_rnd;
    logic signed [VBits-1:0]   w_vr;
    logic signed [VBits-1:0]   w_fin;
    logic signed [SB-1:0]      w_sat;

    localparam logic signed [AccBits-1:0] HHalf = AccBits'(1) <<< (F - G - 1);
    localparam logic signed [VBits-1:0]   VHalf = VBits'(1) <<< (F + G - 1);

    // step 0: s00*(1-fx), 1: +s01*fx -> top, 2: s10, 3: +s11 -> bot, 4: vertical
    always_comb begin
        w_wx  = (i_step[0]) ? $signed({2'b00, i_fx})
                            : $signed((F+2)'(1) <<< F) - $signed({2'b00, i_fx});
        w_prod = AccBits'(i_sample) * AccBits'(w_wx);
        w_sum  = i_step[0] ? (r_acc + w_prod) : w_prod;
        w_rnd  = (w_sum + HHalf) >>> (F - G);
        w_wy0  = $signed((F+2)'(1) <<< F) - $signed({2'b00, i_fy});
        w_wy1  = $signed({2'b00, i_fy});
        w_vr   = VBits'(r_top) * VBits'(w_wy0) + VBits'(r_bot) * VBits'(w_wy1);
        w_fin  = (r_v + VHalf) >>> (F + G);
        if (w_fin > VBits'((1 <<< (SB - 1)) - 1)) begin
            w_sat = {1'b0, {(SB-1){1'b1}}};
        end else if (w_fin < -$signed(VBits'(1 <<< (SB - 1)))) begin
            w_sat = {1'b1, {(SB-1){1'b0}}};
        end else begin
            w_sat = w_fin[SB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_step)
            3'd0, 3'd2: r_acc <= w_sum;
            3'd1:       r_top <= HBits'(w_rnd);
            3'd3:       r_bot <= HBits'(w_rnd);
            3'd4:       r_v   <= w_vr;
            default:    r_acc <= r_acc;
        endcase
    end

    assign o_result = w_sat;
endmodule
